// File: sv/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/stff_pkg.sv
package stff_pkg;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_NONE = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_BAD  = 2'd3;

   localparam logic [2:0] FN_ADD          = 3'd0;
   localparam logic [2:0] FN_REMOVE_VALUE = 3'd1;
   localparam logic [2:0] FN_REMOVE_AT    = 3'd2;
   localparam logic [2:0] FN_GET          = 3'd3;
   localparam logic [2:0] FN_FIRST        = 3'd4;
   localparam logic [2:0] FN_NEXT         = 3'd5;

   typedef logic [1:0] status_type;
   typedef logic [2:0] func_type;

endpackage

// File: sv/slot_table_first_free_core.sv
// Slot table with first-free placement. A zero entry is an empty slot.
// Request channel (req_valid/req_ready): one operation per beat, with
// req_func, req_item_value and req_slot_index. Response channel
// (rsp_valid/rsp_ready): exactly one beat per request, carrying status,
// result index, read value and the occupied count after the operation.
// The table sits in one synchronous memory with a registered read. Each
// request is handled on its own: the sequencer reads one slot per cycle
// and modifies or writes back at most one slot. Add, remove-by-value,
// first and next walk the memory from their start slot until a match or
// the last slot, while a bad request, remove-at and get end at their
// start slot; another request is taken only after the response beat is
// loaded.
// After reset a clearing pass writes zero to every slot, one per cycle;
// req_ready stays low until it is done.
// A response waits in its output register while rsp_ready is low; the
// next request may be accepted meanwhile, and it holds its final step
// until the output register is free again.
module slot_table_first_free_core #(
   parameter int SLOTS      = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  stff_pkg::func_type  req_func,
   input  logic [31:0]         req_item_value,
   input  logic [5:0]          req_slot_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output stff_pkg::status_type rsp_status,
   output logic [5:0]          rsp_result_index,
   output logic [31:0]         rsp_read_value,
   output logic [6:0]          rsp_occupied_count
);
   import stff_pkg::*;

   localparam int ADDR_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam logic [ADDR_W-1:0] LAST = ADDR_W'(SLOTS - 1);
   localparam logic [ADDR_W+5:0] SLOTS_WIDE = (ADDR_W + 6)'(SLOTS);

   typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN} state_type;

   state_type               state_ff, state_in;
   logic [ADDR_W-1:0]       clr_ff, clr_in;
   logic [ADDR_W-1:0]       ptr_ff, ptr_in;
   func_type                func_ff, func_in;
   logic [VALUE_BITS-1:0]   val_ff, val_in;
   logic                    early_ff, early_in;
   status_type              early_st_ff, early_st_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [5:0]              rsp_index_ff, rsp_index_in;
   logic [31:0]             rsp_value_ff, rsp_value_in;
   logic [6:0]              rsp_count_ff, rsp_count_in;

   logic [VALUE_BITS-1:0]   slot_mem_ff [SLOTS];
   logic [VALUE_BITS-1:0]   rdata_ff;

   logic [VALUE_BITS+31:0]  val_wide;
   logic [VALUE_BITS-1:0]   req_val;
   logic [ADDR_W+5:0]       idx_wide;
   logic [ADDR_W+5:0]       nxt_wide;
   logic                    idx_ok;
   logic                    nxt_ok;
   logic                    dec_early;
   status_type              dec_st;
   logic [ADDR_W-1:0]       dec_start;
   logic                    accept;

   logic                    hit;
   logic                    at_last;
   logic                    done;
   logic                    out_free;
   logic                    fire;
   status_type              res_st;
   logic                    res_wr;
   logic [VALUE_BITS-1:0]   res_wval;
   logic [VALUE_BITS-1:0]   res_rd;
   logic [CNT_W-1:0]        res_cnt;
   logic [ADDR_W+5:0]       ptr_wide;
   logic [VALUE_BITS+31:0]  rd_wide;
   logic [CNT_W+6:0]        cnt_wide;

   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   logic [VALUE_BITS-1:0]   mem_wdata;
   logic [ADDR_W-1:0]       mem_raddr;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   assign val_wide = {{VALUE_BITS{1'b0}}, req_item_value};
   assign req_val  = val_wide[VALUE_BITS-1:0];
   assign idx_wide = {{ADDR_W{1'b0}}, req_slot_index};
   assign nxt_wide = idx_wide + (ADDR_W + 6)'(1);
   assign idx_ok   = idx_wide < SLOTS_WIDE;
   assign nxt_ok   = nxt_wide < SLOTS_WIDE;

   always_comb begin
      dec_early = 1'b1;
      dec_st    = ST_BAD;
      dec_start = '0;
      case (req_func)
         FN_ADD, FN_REMOVE_VALUE: begin
            dec_early = (req_val == '0);
         end
         FN_REMOVE_AT, FN_GET: begin
            dec_early = !idx_ok;
            dec_start = idx_wide[ADDR_W-1:0];
         end
         FN_FIRST: begin
            dec_early = 1'b0;
         end
         FN_NEXT: begin
            if (!idx_ok) begin
               dec_early = 1'b1;
            end else if (!nxt_ok) begin
               dec_st = ST_NONE;
            end else begin
               dec_early = 1'b0;
               dec_start = nxt_wide[ADDR_W-1:0];
            end
         end
         default: begin
            dec_early = 1'b1;
         end
      endcase
   end

   always_comb begin
      case (func_ff)
         FN_ADD:                hit = (rdata_ff == '0);
         FN_REMOVE_VALUE:       hit = (rdata_ff == val_ff);
         FN_FIRST, FN_NEXT:     hit = (rdata_ff != '0);
         default:               hit = 1'b1;
      endcase
   end

   assign at_last  = (ptr_ff == LAST);
   assign done     = early_ff || hit || at_last;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fire     = (state_ff == S_SCAN) && done && out_free;

   always_comb begin
      res_st   = ST_NONE;
      res_wr   = 1'b0;
      res_wval = '0;
      res_rd   = '0;
      res_cnt  = cnt_ff;
      if (early_ff) begin
         res_st = early_st_ff;
      end else if (hit) begin
         case (func_ff)
            FN_ADD: begin
               res_st   = ST_OK;
               res_wr   = 1'b1;
               res_wval = val_ff;
               res_cnt  = cnt_ff + CNT_W'(1);
            end
            FN_REMOVE_VALUE: begin
               res_st = ST_OK;
               res_wr = 1'b1;
               if (cnt_ff != '0) begin
                  res_cnt = cnt_ff - CNT_W'(1);
               end
            end
            FN_REMOVE_AT: begin
               if (rdata_ff != '0) begin
                  res_st = ST_OK;
                  res_wr = 1'b1;
                  if (cnt_ff != '0) begin
                     res_cnt = cnt_ff - CNT_W'(1);
                  end
               end
            end
            FN_GET: begin
               res_st = ST_OK;
               res_rd = rdata_ff;
            end
            default: begin
               res_st = ST_OK;
            end
         endcase
      end else if (func_ff == FN_ADD) begin
         res_st = ST_FULL;
      end
   end

   assign ptr_wide = {6'b0, ptr_ff};
   assign rd_wide  = {32'b0, res_rd};
   assign cnt_wide = {7'b0, res_cnt};

   assign mem_we    = (state_ff == S_CLEAR) || (fire && res_wr);
   assign mem_waddr = (state_ff == S_CLEAR) ? clr_ff : ptr_ff;
   assign mem_wdata = (state_ff == S_CLEAR) ? '0 : res_wval;

   always_comb begin
      if (state_ff == S_SCAN) begin
         mem_raddr = (done || at_last) ? ptr_ff : ptr_ff + ADDR_W'(1);
      end else begin
         mem_raddr = dec_start;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem_ff[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= slot_mem_ff[mem_raddr];
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      ptr_in       = ptr_ff;
      func_in      = func_ff;
      val_in       = val_ff;
      early_in     = early_ff;
      early_st_in  = early_st_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in    = S_SCAN;
               ptr_in      = dec_start;
               func_in     = req_func;
               val_in      = req_val;
               early_in    = dec_early;
               early_st_in = dec_st;
            end
         end
         S_SCAN: begin
            if (fire) begin
               state_in      = S_IDLE;
               cnt_in        = res_cnt;
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_st;
               rsp_index_in  = (res_st == ST_OK) ? ptr_wide[5:0] : 6'b0;
               rsp_value_in  = rd_wide[31:0];
               rsp_count_in  = cnt_wide[6:0];
            end else if (!done) begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff        <= ptr_in;
      func_ff       <= func_in;
      val_ff        <= val_in;
      early_ff      <= early_in;
      early_st_ff   <= early_st_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_index   = rsp_index_ff;
   assign rsp_read_value     = rsp_value_ff;
   assign rsp_occupied_count = rsp_count_ff;

endmodule

// File: sv/stff_checker.sv
`include "assert_macros.svh"

module stff_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input stff_pkg::status_type rsp_status,
   input logic [5:0]           rsp_result_index,
   input logic [31:0]          rsp_read_value,
   input logic [6:0]           rsp_occupied_count
);
   import stff_pkg::*;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_result_index) && $stable(rsp_read_value) && $stable(rsp_occupied_count), "response beat changed while stalled")
   `ASSERT_SAME(a_fail_fields_zero, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_result_index == 6'b0 && rsp_read_value == 32'b0, "failed operation returned a nonzero index or value")
   `ASSERT_SAME(a_read_only_get, clock, reset, rsp_valid && (rsp_status == ST_NONE || rsp_status == ST_FULL || rsp_status == ST_BAD), rsp_read_value == 32'b0, "read value given outside a get")
   `ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && !req_ready, "block not quiet after reset")
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "request taken while another is in flight")

endmodule

bind slot_table_first_free_core stff_checker u_stff_checker (.*);
